### rtl/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int MOD_W  = 31;
    localparam int BASE_W = 32;
    localparam int EXP_W  = 32;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register index taken from paddr above the byte offset
    localparam logic [PADDR_W-3:0] REG_MODULUS = '0;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

    typedef enum logic
    {
        ACT_POW = 1'b0,
        ACT_INV = 1'b1
    } action_t;

    typedef struct packed
    {
        logic              start;
        logic [MOD_W-1:0]  x;
        logic [BASE_W-1:0] y;
    } mm_req_t;

    typedef struct packed
    {
        logic             done;
        logic [MOD_W-1:0] product;
    } mm_rsp_t;

endpackage

### rtl/mexp_if.sv
`timescale 1ns / 1ps

interface mexp_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [mexp_pkg::BASE_W-1:0] base;
    logic [mexp_pkg::EXP_W-1:0]  exponent;

    modport source (output valid, output action, output base, output exponent, input ready);
    modport sink (input valid, input action, input base, input exponent, output ready);
endinterface

interface mexp_out_if;
    logic                       valid;
    logic                       ready;
    logic [mexp_pkg::MOD_W-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

### rtl/mexp_modmul.sv
`timescale 1ns / 1ps

module mexp_modmul
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [mexp_pkg::MOD_W-1:0] modulus,
    input  mexp_pkg::mm_req_t          req,
    output mexp_pkg::mm_rsp_t          rsp
);

    localparam int STEPS = mexp_pkg::BASE_W;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int ACC_W = mexp_pkg::MOD_W + 2;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [mexp_pkg::MOD_W-1:0]  x_reg, x_next;
    logic [mexp_pkg::BASE_W-1:0] y_reg, y_next;
    logic [mexp_pkg::MOD_W-1:0]  r_reg, r_next;

    logic [ACC_W-1:0] t1;
    logic [ACC_W-1:0] t2;
    logic [ACC_W-1:0] t3;
    logic [ACC_W-1:0] m1;
    logic [ACC_W-1:0] m2;
    logic [ACC_W-1:0] r_sel;

    // one step of interleaved shift-add multiply with reduction
    always_comb
    begin
        m1 = {2'b00, modulus};
        m2 = {1'b0, modulus, 1'b0};
        t1 = {1'b0, r_reg, 1'b0} + (y_reg[STEPS-1] ? {2'b00, x_reg} : '0);
        t2 = t1 - m1;
        t3 = t1 - m2;
        if (t1 >= m2)
        begin
            r_sel = t3;
        end
        else if (t1 >= m1)
        begin
            r_sel = t2;
        end
        else
        begin
            r_sel = t1;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        r_next    = r_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            x_next    = req.x;
            y_next    = req.y;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = r_sel[mexp_pkg::MOD_W-1:0];
            y_next   = {y_reg[STEPS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        r_reg <= r_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = r_reg;

endmodule

### rtl/mexp_seq.sv
`timescale 1ns / 1ps

module mexp_seq
#(
    parameter int EXP_BITS = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [mexp_pkg::MOD_W-1:0] modulus,
    mexp_in_if.sink                    in_ch,
    mexp_out_if.source                 out_ch,
    output mexp_pkg::mm_req_t          mm_req,
    input  mexp_pkg::mm_rsp_t          mm_rsp
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_REDUCE,
        S_MUL,
        S_SQR,
        S_FINISH
    } state_t;

    state_t                     state_reg, state_next;
    logic [EXP_BITS-1:0]        e_reg, e_next;
    logic [mexp_pkg::MOD_W-1:0] acc_reg, acc_next;
    logic [mexp_pkg::MOD_W-1:0] sq_reg, sq_next;
    logic [mexp_pkg::MOD_W-1:0] result_reg, result_next;
    logic                       out_valid_reg, out_valid_next;
    mexp_pkg::mm_req_t          req_reg, req_next;

    logic [63:0]                e_full;
    logic [EXP_BITS-1:0]        e_shift;
    logic [EXP_BITS-1:0]        e_dec;
    logic [mexp_pkg::MOD_W-1:0] acc_dec;
    logic                       in_accept;
    logic                       small_mod;

    assign in_accept = in_ch.valid && (state_reg == S_IDLE);
    assign small_mod = (modulus < mexp_pkg::MOD_W'(2));

    always_comb
    begin
        if (mexp_pkg::action_t'(in_ch.action) == mexp_pkg::ACT_INV)
        begin
            e_full = {33'd0, modulus - mexp_pkg::MOD_W'(2)};
        end
        else
        begin
            e_full = {32'd0, in_ch.exponent};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        e_next         = e_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        req_next       = req_reg;
        req_next.start = 1'b0;
        e_shift        = e_reg >> 1;
        e_dec          = e_reg;
        acc_dec        = acc_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    e_next = e_full[EXP_BITS-1:0];
                    if (small_mod)
                    begin
                        acc_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        acc_next       = mexp_pkg::MOD_W'(1);
                        req_next.start = 1'b1;
                        req_next.x     = mexp_pkg::MOD_W'(1);
                        req_next.y     = in_ch.base;
                        state_next     = S_REDUCE;
                    end
                end
            end
            S_REDUCE, S_SQR:
            begin
                if (mm_rsp.done)
                begin
                    sq_next = mm_rsp.product;
                    if (state_reg == S_SQR)
                    begin
                        e_dec  = e_shift;
                        e_next = e_shift;
                    end
                    if (e_dec == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (e_dec[0])
                    begin
                        req_next.start = 1'b1;
                        req_next.x     = acc_reg;
                        req_next.y     = {1'b0, mm_rsp.product};
                        state_next     = S_MUL;
                    end
                    else
                    begin
                        req_next.start = 1'b1;
                        req_next.x     = mm_rsp.product;
                        req_next.y     = {1'b0, mm_rsp.product};
                        state_next     = S_SQR;
                    end
                end
            end
            S_MUL:
            begin
                if (mm_rsp.done)
                begin
                    acc_dec  = mm_rsp.product;
                    acc_next = acc_dec;
                    if (e_shift == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        req_next.start = 1'b1;
                        req_next.x     = sq_reg;
                        req_next.y     = {1'b0, sq_reg};
                        state_next     = S_SQR;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    result_next    = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            req_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            req_reg       <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        result_reg <= result_next;
    end

    assign in_ch.ready   = (state_reg == S_IDLE);
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.result = result_reg;
    assign mm_req        = req_reg;

endmodule

### rtl/modular_exponentiation_core.sv
`timescale 1ns / 1ps

// Modular exponentiation core: each item returns base^exponent mod modulus
// (action 0) or the Fermat inverse base^(modulus-2) mod modulus (action 1),
// using right-to-left square-and-multiply over the low EXP_BITS exponent bits.
// All arithmetic runs through one shift-add modular multiplier that retires
// one multiplier bit per cycle. An item first reduces the base with one
// product, then takes S squarings and P multiplies, where S is the position
// of the highest set exponent bit and P the number of set bits; a zero
// exponent needs only the reduction. A modulus below two returns 0 without
// any product. The input is not ready while an item is in work;
// the finished result sits in an output register so the next item can be
// taken while it waits. The modulus is written over APB at byte address 0
// and should only be changed while the core is idle.
module modular_exponentiation_core
#(
    parameter int EXP_BITS = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    mexp_in_if.sink                        in_ch,
    mexp_out_if.source                     out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mexp_pkg::PADDR_W-1:0]   paddr,
    input  logic [mexp_pkg::PDATA_W-1:0]   pwdata,
    output logic [mexp_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);

    logic [mexp_pkg::MOD_W-1:0] modulus_reg, modulus_next;
    logic                       hit_modulus;
    mexp_pkg::mm_req_t          mm_req;
    mexp_pkg::mm_rsp_t          mm_rsp;

    assign hit_modulus = (paddr[mexp_pkg::PADDR_W-1:2] == mexp_pkg::REG_MODULUS);

    always_comb
    begin
        modulus_next = modulus_reg;
        if (psel && penable && pwrite && hit_modulus)
        begin
            modulus_next = pwdata[mexp_pkg::MOD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= mexp_pkg::MODULUS_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = hit_modulus ? {1'b0, modulus_reg} : '0;

    mexp_seq
    #(
        .EXP_BITS (EXP_BITS)
    )
    u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .mm_req  (mm_req),
        .mm_rsp  (mm_rsp)
    );

    mexp_modmul u_modmul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

endmodule
